>>> rtl/core/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg - shared types for the sliding window median filter
// Sample type, configuration register indexes and the structs passed
// between the top level and the sorting cells.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WIN_LEN_W   = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_VALUE    = 2'd1;

  localparam logic [WIN_LEN_W-1:0] WINDOW_LENGTH_RESET = 5'd3;
  localparam sample_t              FILL_VALUE_RESET    = 16'sd0;

  typedef struct packed {
    sample_t value;
    logic    gt;
  } cell_link_t;

  typedef struct packed {
    sample_t sample;
    sample_t fill;
    logic    step;
    logic    load;
  } cell_ctrl_t;

endpackage

>>> rtl/core/swmf_sample_if.sv
// ----------------------------------------------------------------------------
// swmf_sample_if - sample stream channel
// Valid/ready channel carrying one signed sample per transfer.
// ----------------------------------------------------------------------------
interface swmf_sample_if;
  import swmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

>>> rtl/core/swmf_median_if.sv
// ----------------------------------------------------------------------------
// swmf_median_if - median stream channel
// Valid/ready channel carrying one signed median per transfer.
// ----------------------------------------------------------------------------
interface swmf_median_if;
  import swmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median_out;

  modport source (output valid, output median_out, input ready);
  modport sink (input valid, input median_out, output ready);
endinterface

>>> rtl/core/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell - one slot of the sorted window
// Holds one window sample and its age. On a new sample the oldest entry
// drops out of the row and the new sample is inserted in sorted order,
// using the neighbours' values and compare results.
// ----------------------------------------------------------------------------
module swmf_cell #(
  parameter int AGE_W = 4,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swmf_pkg::cell_ctrl_t ctrl,
  input  logic                 active,
  input  logic                 last,
  input  logic [AGE_W-1:0]     age_lim,
  input  swmf_pkg::cell_link_t prev_link,
  input  logic [AGE_W-1:0]     prev_age,
  input  swmf_pkg::cell_link_t next_link,
  input  logic [AGE_W-1:0]     next_age,
  input  logic                 rb_in,
  output logic                 rb_out,
  output swmf_pkg::cell_link_t link,
  output logic [AGE_W-1:0]     age
);
  import swmf_pkg::*;

  sample_t          value;
  sample_t          value_next;
  logic [AGE_W-1:0] age_next;
  logic             c_prev;
  logic             c_self;
  sample_t          w_prev_value;
  logic [AGE_W-1:0] w_prev_age;
  sample_t          w_self_value;
  logic [AGE_W-1:0] w_self_age;

  assign link.value = value;
  assign link.gt    = value > ctrl.sample;
  assign rb_out     = rb_in | (active && (age == age_lim));

  always_comb begin
    c_prev       = rb_in ? link.gt : prev_link.gt;
    c_self       = rb_out ? next_link.gt : link.gt;
    w_prev_value = rb_in ? value : prev_link.value;
    w_prev_age   = rb_in ? age : prev_age;
    w_self_value = rb_out ? next_link.value : value;
    w_self_age   = rb_out ? next_age : age;
    if (c_prev) begin
      value_next = w_prev_value;
      age_next   = w_prev_age + AGE_W'(1);
    end else if (c_self || last) begin
      value_next = ctrl.sample;
      age_next   = '0;
    end else begin
      value_next = w_self_value;
      age_next   = w_self_age + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= FILL_VALUE_RESET;
      age   <= AGE_W'(INDEX);
    end else if (ctrl.load) begin
      value <= ctrl.fill;
      age   <= AGE_W'(INDEX);
    end else if (ctrl.step && active) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

>>> rtl/core/sliding_window_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter - running median over a configurable window
// Each sample transfer on the input channel yields one median transfer on
// the output channel: the middle value of the newest window_length samples,
// or for an even length the mean of the middle pair truncated toward zero.
// The window is a row of sorting cells kept in ascending order; a new sample
// replaces the oldest entry in one update of the whole row, so one sample is
// taken per clock while the receiver keeps up. Its median is then registered
// into the output register, which raises output valid. Throughput is one
// item per cycle unless the receiver stalls, set by the insertion across the
// cell row; a sample is first inserted into the cells and its median is then
// loaded into the median register. When the receiver stalls, the output
// register holds its result and one further sample may enter the cells;
// ready then drops until the output transfer completes.
// Reset (synchronous, rst) sets window_length to 3 and fill_value to 0 and
// loads every cell with the fill value. A write to either register reloads
// every cell with the fill value in the same cycle; lengths of zero read as
// one and lengths above MAX_WINDOW as MAX_WINDOW.
// ----------------------------------------------------------------------------
module sliding_window_median_filter #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  swmf_sample_if.sink                      samples,
  swmf_median_if.source                    medians,
  input  logic                             cfg_we,
  input  logic [swmf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [swmf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import swmf_pkg::*;

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  function automatic logic [LEN_W-1:0] eff_len_of(input logic [WIN_LEN_W-1:0] w);
    logic [LEN_W-1:0] r;
    if (w == '0) begin
      r = LEN_W'(1);
    end else if (int'(w) > MAX_WINDOW) begin
      r = LEN_W'(MAX_WINDOW);
    end else begin
      r = LEN_W'(w);
    end
    return r;
  endfunction

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] eff_len_next;
  sample_t          fill;
  sample_t          fill_next;
  logic             cfg_load;
  cell_ctrl_t       ctrl;
  logic [AGE_W-1:0] age_lim;
  logic [LEN_W-1:0] lo_idx;
  logic [LEN_W-1:0] hi_idx;

  cell_link_t       links [MAX_WINDOW];
  logic [AGE_W-1:0] ages  [MAX_WINDOW];
  logic [MAX_WINDOW:0] rb;

  logic             pend;
  logic             out_valid;
  sample_t          median;
  logic             in_xfer;
  logic             out_adv;
  sample_t          lo_v;
  sample_t          hi_v;
  logic signed [SAMPLE_W:0] pair_sum;
  logic signed [SAMPLE_W:0] pair_half;

  always_comb begin
    eff_len_next = eff_len;
    fill_next    = fill;
    cfg_load     = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: begin
          eff_len_next = eff_len_of(cfg_data[WIN_LEN_W-1:0]);
          cfg_load     = 1'b1;
        end
        REG_FILL_VALUE: begin
          fill_next = sample_t'(cfg_data);
          cfg_load  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len <= eff_len_of(WINDOW_LENGTH_RESET);
      fill    <= FILL_VALUE_RESET;
    end else begin
      eff_len <= eff_len_next;
      fill    <= fill_next;
    end
  end

  assign out_adv       = pend && (!out_valid || medians.ready);
  assign samples.ready = !pend || out_adv;
  assign in_xfer       = samples.valid && samples.ready;

  assign ctrl.sample = samples.sample_in;
  assign ctrl.fill   = fill_next;
  assign ctrl.step   = in_xfer;
  assign ctrl.load   = cfg_load;

  assign age_lim = AGE_W'(eff_len - LEN_W'(1));
  assign lo_idx  = (eff_len - LEN_W'(1)) >> 1;
  assign hi_idx  = eff_len >> 1;
  assign rb[0]   = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_link_t       prev_link;
    logic [AGE_W-1:0] prev_age;
    cell_link_t       next_link;
    logic [AGE_W-1:0] next_age;

    if (i == 0) begin : g_first
      assign prev_link = '0;
      assign prev_age  = '0;
    end else begin : g_mid_prev
      assign prev_link = links[i-1];
      assign prev_age  = ages[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign next_link = '0;
      assign next_age  = '0;
    end else begin : g_mid_next
      assign next_link = links[i+1];
      assign next_age  = ages[i+1];
    end

    swmf_cell #(
      .AGE_W (AGE_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .active    (LEN_W'(i) < eff_len),
      .last      (LEN_W'(i) == (eff_len - LEN_W'(1))),
      .age_lim   (age_lim),
      .prev_link (prev_link),
      .prev_age  (prev_age),
      .next_link (next_link),
      .next_age  (next_age),
      .rb_in     (rb[i]),
      .rb_out    (rb[i+1]),
      .link      (links[i]),
      .age       (ages[i])
    );
  end

  always_comb begin
    lo_v = '0;
    hi_v = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (LEN_W'(i) == lo_idx) begin
        lo_v = links[i].value;
      end
      if (LEN_W'(i) == hi_idx) begin
        hi_v = links[i].value;
      end
    end
    pair_sum  = {lo_v[SAMPLE_W-1], lo_v} + {hi_v[SAMPLE_W-1], hi_v};
    pair_half = (pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]}) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        pend <= 1'b1;
      end else if (out_adv) begin
        pend <= 1'b0;
      end
      if (out_adv) begin
        out_valid <= 1'b1;
      end else if (medians.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      median <= pair_half[SAMPLE_W-1:0];
    end
  end

  assign medians.valid      = out_valid;
  assign medians.median_out = median;

endmodule

>>> dv/tb_sliding_window_median_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_filter - self-checking bench for the median filter
// Drives signed samples through the valid/ready input channel and compares
// each median transfer against a running-median predictor kept in a small
// scoreboard class. A directed pass covers the sample extremes, odd and
// even windows, zero and oversize lengths, fill reloads and writes to
// unused register indexes. Random phases then follow, each with its own
// register setting and its own idling pattern on both channels.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_filter;
  import swmf_pkg::*;

  localparam int MAX_WINDOW    = 16;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 15;
  localparam int PHASE_ITEMS   = 100;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;

  typedef enum int {
    IDLE_NONE,
    IDLE_FULL,
    IDLE_SPARSE
  } idle_mode_e;

  class median_book;
    sample_t                history[MAX_WINDOW];
    logic [WIN_LEN_W-1:0]   win_len;
    sample_t                fill;
    sample_t                medians_due[$];
    int                     mismatches;
    int                     samples_taken;
    int                     medians_seen;

    function new();
      mismatches    = 0;
      samples_taken = 0;
      medians_seen  = 0;
      win_len       = WINDOW_LENGTH_RESET;
      fill          = FILL_VALUE_RESET;
      refill();
    endfunction

    function void refill();
      foreach (history[i]) history[i] = fill;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_LENGTH: begin
          win_len = data[WIN_LEN_W-1:0];
          refill();
        end
        REG_FILL_VALUE: begin
          fill = sample_t'(data);
          refill();
        end
        default: ;
      endcase
    endfunction

    function sample_t window_median();
      int len;
      int sorted[MAX_WINDOW];
      int v;
      int j;
      int mid;
      len = win_len;
      if (len == 0) len = 1;
      if (len > MAX_WINDOW) len = MAX_WINDOW;
      for (int i = 0; i < len; i++) begin
        v = history[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      if (len % 2 == 1) mid = sorted[len/2];
      else mid = (sorted[len/2-1] + sorted[len/2]) / 2;
      return sample_t'(mid);
    endfunction

    function void take_sample(sample_t s);
      for (int i = MAX_WINDOW - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = s;
      medians_due.push_back(window_median());
      samples_taken++;
    endfunction

    function void check_median(sample_t got);
      sample_t want;
      medians_seen++;
      if (medians_due.size() == 0) begin
        $error("median_out: no median pending, got %0d", got);
        mismatches++;
      end else begin
        want = medians_due.pop_front();
        if (got !== want) begin
          $error("median_out mismatch: expected %0d, got %0d", want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return medians_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  swmf_sample_if sample_ch();
  swmf_median_if median_ch();

  median_book book = new();
  idle_mode_e src_mode = IDLE_FULL;
  idle_mode_e snk_mode = IDLE_FULL;
  sample_t    last_sample = '0;
  int         cfg_writes = 0;
  int         quiet_cycles = 0;

  sliding_window_median_filter #(
    .MAX_WINDOW(MAX_WINDOW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(sample_ch),
    .medians(median_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_cycles(idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic logic [WIN_LEN_W-1:0] pick_length();
    case ($urandom_range(0, 5))
      0: return 5'd16;
      1: return 5'd1;
      2: return ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(2, 15));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'(int'($urandom_range(0, 8)) - 4);
      3: return book.fill;
      4: return last_sample;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    gap = idle_cycles(src_mode);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_in <= s;
    do @(posedge clk); while (!sample_ch.ready);
    book.take_sample(s);
    last_sample = s;
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    book.write_reg(idx, data);
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : sink_side
    int stall;
    median_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_cycles(snk_mode);
      if (stall > 0) begin
        median_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      median_ch.ready <= 1'b1;
      do @(posedge clk); while (!median_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (median_ch.valid && median_ch.ready) book.check_median(median_ch.median_out);
      if ((sample_ch.valid && sample_ch.ready) || (median_ch.valid && median_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] data;
    int                    n;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.sample_in <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: odd window of three over a zero fill
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(-16'sd1);
    settle();

    // even window: middle pair averaged toward zero
    cfg_write(REG_WINDOW_LENGTH, 16'd2);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    settle();

    // unused indexes: history must survive
    cfg_write(REG_SPARE_A, 16'hffff);
    cfg_write(REG_SPARE_B, 16'h0001);
    send_sample(-16'sd3);
    settle();

    // zero length reads as one, upper data bits ignored
    cfg_write(REG_FILL_VALUE, 16'h8000);
    cfg_write(REG_WINDOW_LENGTH, 16'hffe0);
    send_sample(16'sd5);
    send_sample(S_MIN);
    settle();

    // oversize length saturates
    cfg_write(REG_WINDOW_LENGTH, 16'h001f);
    cfg_write(REG_FILL_VALUE, 16'h7fff);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    settle();

    cfg_write(REG_WINDOW_LENGTH, 16'd16);
    send_sample(S_MIN);
    send_sample(S_MIN);
    settle();

    cfg_write(REG_WINDOW_LENGTH, 16'd17);
    send_sample(16'sd1);
    settle();

    cfg_write(REG_FILL_VALUE, 16'h5555);
    cfg_write(REG_WINDOW_LENGTH, 16'd15);
    send_sample(16'shaaaa);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      src_mode = idle_mode_e'($urandom_range(0, 2));
      snk_mode = idle_mode_e'($urandom_range(0, 2));
      data = 16'($urandom);
      data[WIN_LEN_W-1:0] = pick_length();
      case ($urandom_range(0, 3))
        0: cfg_write(REG_WINDOW_LENGTH, data);
        1: cfg_write(REG_FILL_VALUE, 16'($urandom));
        2: begin
          cfg_write(REG_FILL_VALUE, 16'($urandom));
          cfg_write(REG_WINDOW_LENGTH, data);
        end
        default: begin
          cfg_write(REG_WINDOW_LENGTH, data);
          cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
        end
      endcase
      n = PHASE_ITEMS;
      for (int i = 0; i < n; i++) send_sample(pick_sample());
      settle();
    end

    $display("Run covered %0d samples and %0d medians across %0d register writes,",
             book.samples_taken, book.medians_seen, cfg_writes);
    $display("with window lengths from zero to oversize and fills at both extremes.");
    if (book.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/swmf_pkg.sv
rtl/core/swmf_sample_if.sv
rtl/core/swmf_median_if.sv
rtl/core/swmf_cell.sv
rtl/core/sliding_window_median_filter.sv
dv/tb_sliding_window_median_filter.sv
